/* design/resource_write_hazard_scoreboard_macros.svh */
// Assertion helpers shared by the scoreboard modules.
`ifndef RESOURCE_WRITE_HAZARD_SCOREBOARD_MACROS_SVH
`define RESOURCE_WRITE_HAZARD_SCOREBOARD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RWHS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rwhs assertion failed");

// Next-cycle implication, checked outside reset.
`define RWHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwhs assertion failed");

`endif

/* design/rwhs_pkg.sv */
package rwhs_pkg;

  localparam int unsigned TABLE_ENTRIES_DFLT = 64;
  localparam int unsigned KEY_W              = 33;

  typedef enum logic [1:0] {
    REQ_QUERY  = 2'd0,
    REQ_RECORD = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e   req_type;
    logic        handle_valid;
    logic        resource_kind;
    logic [15:0] pool_slot;
    logic [15:0] slot_generation;
    logic        group_last;
  } req_t;

  typedef struct packed {
    logic barrier_needed;
    logic group_done;
    logic table_overflow;
  } rsp_t;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

/* design/rwhs_ctrl.sv */
module rwhs_ctrl
  import rwhs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output logic       busy_o,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        busy_o     = 1'b1;
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/rwhs_dp.sv */
module rwhs_dp
  import rwhs_pkg::*;
#(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DFLT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       req_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       result_valid_o,
  output rsp_t       result_o
);

`include "resource_write_hazard_scoreboard_macros.svh"

  localparam int unsigned CW = $clog2(TableEntries + 1);
  localparam int unsigned AW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(TableEntries);

  key_t mem [TableEntries];

  req_t          item_q;
  key_t          rd_data_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q;
  logic          pend_q, hit_q;
  logic          sticky_q, sticky_d;
  logic          accum_q, accum_d;
  logic          res_vld_q;
  rsp_t          res_q, res_d;

  key_t key;
  logic need_scan, issue, match_now, full, wr_en, acc_hit;

  assign key       = {item_q.resource_kind, item_q.slot_generation, item_q.pool_slot};
  assign need_scan = item_q.handle_valid &&
                     (item_q.req_type == REQ_QUERY || item_q.req_type == REQ_RECORD);
  assign match_now = pend_q && (rd_data_q == key);
  assign issue     = cmd_i.scan && need_scan && !hit_q && (idx_q != count_q);
  assign full      = (count_q == FULL_CNT);

  // Pipelined scan: one read issued per cycle, compared against the key in the next cycle.
  assign status_o.scan_done = !need_scan || hit_q || ((idx_q == count_q) && !pend_q);

  always_comb begin
    count_d  = count_q;
    sticky_d = sticky_q;
    accum_d  = accum_q;
    wr_en    = 1'b0;
    acc_hit  = accum_q | hit_q;
    res_d    = '0;
    unique case (item_q.req_type)
      REQ_QUERY: begin
        res_d.barrier_needed = acc_hit | sticky_q;
        res_d.group_done     = item_q.group_last;
        accum_d              = item_q.group_last ? 1'b0 : acc_hit;
      end
      REQ_RECORD: begin
        if (item_q.handle_valid && !hit_q) begin
          if (full) begin
            sticky_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
      end
      REQ_CLEAR: begin
        count_d  = '0;
        sticky_d = 1'b0;
      end
      default: begin
      end
    endcase
    res_d.table_overflow = sticky_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && wr_en) begin
      mem[count_q[AW-1:0]] <= key;
    end
    if (issue) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= req_i;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      hit_q     <= 1'b0;
      sticky_q  <= 1'b0;
      accum_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.finish;
      if (cmd_i.load) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
        hit_q  <= 1'b0;
      end else begin
        pend_q <= issue;
        if (issue) begin
          idx_q <= idx_q + CW'(1);
        end
        if (match_now) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q  <= count_d;
        sticky_q <= sticky_d;
        accum_q  <= accum_d;
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  `RWHS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FULL_CNT)
  `RWHS_ASSERT_NOW(a_idx_bound, 1'b1, idx_q <= count_q)
  `RWHS_ASSERT_NOW(a_sticky_full, sticky_q, full)

endmodule

/* design/resource_write_hazard_scoreboard.sv */
// An accepted transfer is loaded into the item register; a valid query or record then
// searches the table in the scan state; at finish the result and strobe are registered.
// Busy stays high until the search ends; the next item can start the cycle after, so
// items do not overlap, and the one-entry-per-cycle scan of the single-read-port key
// memory sets the item rate. The receiver cannot stall results.
// Reset empties the table (fill count to zero) and clears overflow and group state.
module resource_write_hazard_scoreboard
  import rwhs_pkg::*;
#(
  parameter int unsigned TableEntries = TABLE_ENTRIES_DFLT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic result_valid_o,
  output rsp_t result_o
);

`include "resource_write_hazard_scoreboard_macros.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rwhs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  rwhs_dp #(
    .TableEntries(TableEntries)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `RWHS_ASSERT_NOW(a_result_idle, result_valid_o, !busy)
  `RWHS_ASSERT_NEXT(a_accept_result, start && !busy, !result_valid_o)

endmodule

/* tb/sv/resource_write_hazard_scoreboard_checker.sv */
module resource_write_hazard_scoreboard_checker
  import rwhs_pkg::*;
#(
  parameter int unsigned Entries = TABLE_ENTRIES_DFLT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic rsp_valid_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  key_t               written_keys [Entries];
  logic [Entries-1:0] occupied;
  logic               overflow_q;
  logic               hit_accum_q;
  rsp_t               hazard_rsp_q [$];
  rsp_t               want;
  int                 mismatches;

  function automatic bit key_written(key_t k);
    for (int i = 0; i < Entries; i++) begin
      if (occupied[i] && written_keys[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the scoreboard state by one transfer and returns its result.
  function automatic rsp_t predict_hazard(req_t r);
    rsp_t p;
    key_t k;
    int   free_idx;
    p = '0;
    k = {r.resource_kind, r.slot_generation, r.pool_slot};
    free_idx = -1;
    case (r.req_type)
      REQ_QUERY: begin
        if (r.handle_valid && key_written(k)) hit_accum_q = 1'b1;
        p.barrier_needed = hit_accum_q | overflow_q;
        p.group_done     = r.group_last;
        if (r.group_last) hit_accum_q = 1'b0;
      end
      REQ_RECORD: begin
        if (r.handle_valid && !key_written(k)) begin
          for (int i = 0; i < Entries; i++) begin
            if (!occupied[i]) begin
              free_idx = i;
              break;
            end
          end
          if (free_idx >= 0) begin
            written_keys[free_idx] = k;
            occupied[free_idx]     = 1'b1;
          end else begin
            overflow_q = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        // an open query group keeps its hits across a clear
        occupied   = '0;
        overflow_q = 1'b0;
      end
      default: ;
    endcase
    p.table_overflow = overflow_q;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied    = '0;
      overflow_q  = 1'b0;
      hit_accum_q = 1'b0;
      hazard_rsp_q.delete();
      mismatches  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rsp_valid_i) begin
        if (hazard_rsp_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result with nothing pending: barrier=%b done=%b ovf=%b",
                     $realtime, rsp_i.barrier_needed, rsp_i.group_done,
                     rsp_i.table_overflow);
          end
          mismatches++;
        end else begin
          want = hazard_rsp_q.pop_front();
          if (want.barrier_needed !== rsp_i.barrier_needed ||
              want.group_done !== rsp_i.group_done ||
              want.table_overflow !== rsp_i.table_overflow) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch barrier exp %b got %b, done exp %b got %b, ovf exp %b got %b",
                       $realtime, want.barrier_needed, rsp_i.barrier_needed,
                       want.group_done, rsp_i.group_done,
                       want.table_overflow, rsp_i.table_overflow);
            end
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) hazard_rsp_q.push_back(predict_hazard(req_i));
      fail_count_o <= mismatches;
      pending_o    <= hazard_rsp_q.size();
    end
  end

endmodule

/* tb/sv/resource_write_hazard_scoreboard_tb.sv */
module resource_write_hazard_scoreboard_tb;
  import rwhs_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned TailCycles  = TABLE_ENTRIES_DFLT + 16;

  localparam key_t KeyZero    = '0;
  localparam key_t KeyOnes    = '1;
  localparam key_t KeyMixed   = 33'h1_2345_6789;
  localparam key_t KeyKindOff = 33'h1_0000_0000;
  localparam key_t KeyGenOff  = 33'h0_0001_0000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  req_t        req_i  = '0;
  logic        busy;
  logic        result_valid_o;
  rsp_t        result_o;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int unsigned sent_items;
  int unsigned frame_idx;
  bit          steady_run = 1'b0;
  key_t        frame_keys [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  resource_write_hazard_scoreboard u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  resource_write_hazard_scoreboard_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .rsp_valid_i  (result_valid_o),
    .rsp_i        (result_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("resource_write_hazard_scoreboard_tb NOT OK");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic key_t random_key();
    key_t k;
    k[32]   = 1'($urandom_range(0, 1));
    k[31:0] = $urandom;
    return k;
  endfunction

  // Half are keys recorded this frame, a quarter are such keys one bit away, the rest random.
  function automatic key_t hazard_key();
    int unsigned sel;
    logic [5:0]  bit_idx;
    key_t        k;
    sel = $urandom_range(0, 99);
    k   = random_key();
    if (frame_keys.size() != 0 && sel < 75) begin
      k = frame_keys[$urandom_range(0, frame_keys.size() - 1)];
      if (sel >= 50) begin
        bit_idx    = 6'($urandom_range(0, 32));
        k[bit_idx] = ~k[bit_idx];
      end
    end
    return k;
  endfunction

  task automatic issue(input req_type_e kind, input bit valid, input key_t k, input bit last);
    req_t        r;
    int unsigned gap;
    r.req_type     = kind;
    r.handle_valid = valid;
    {r.resource_kind, r.slot_generation, r.pool_slot} = k;
    r.group_last   = last;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (kind != REQ_NOP) sent_items++;
    gap = steady_run ? 0 : idle_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic run_frame(input bit fill_table);
    int unsigned n_rec;
    int unsigned n_grp;
    int unsigned choice;
    bit          valid;
    key_t        k;
    issue(REQ_CLEAR, 1'($urandom_range(0, 1)), random_key(), 1'($urandom_range(0, 1)));
    frame_keys.delete();
    n_rec = fill_table ? TABLE_ENTRIES_DFLT + $urandom_range(1, 6) : $urandom_range(0, 20);
    while (n_rec != 0) begin
      choice = $urandom_range(0, 99);
      if (choice < 50) begin
        valid = fill_table || ($urandom_range(0, 9) != 0);
        k     = (!fill_table && $urandom_range(0, 3) == 0) ? hazard_key() : random_key();
        issue(REQ_RECORD, valid, k, 1'($urandom_range(0, 1)));
        if (valid) frame_keys.push_back(k);
        n_rec--;
      end else if (choice < 95) begin
        n_grp = $urandom_range(1, 4);
        for (int g = 0; g < n_grp; g++) begin
          issue(REQ_QUERY, $urandom_range(0, 9) != 0, hazard_key(), g == n_grp - 1);
        end
      end else if (choice < 97) begin
        // group left open, closed later or carried over a clear
        issue(REQ_QUERY, 1'b1, hazard_key(), 1'b0);
      end else begin
        issue(REQ_NOP, 1'($urandom_range(0, 1)), random_key(), 1'($urandom_range(0, 1)));
      end
    end
    n_grp = $urandom_range(1, 3);
    for (int g = 0; g < n_grp; g++) begin
      issue(REQ_QUERY, $urandom_range(0, 9) != 0, hazard_key(), g == n_grp - 1);
    end
  endtask

  initial begin
    sent_items = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(REQ_QUERY,  1'b1, KeyZero,    1'b1);
    issue(REQ_RECORD, 1'b1, KeyZero,    1'b0);
    issue(REQ_RECORD, 1'b1, KeyOnes,    1'b1);
    issue(REQ_QUERY,  1'b1, KeyZero,    1'b1);
    issue(REQ_QUERY,  1'b1, KeyOnes,    1'b1);
    issue(REQ_QUERY,  1'b1, KeyKindOff, 1'b1);
    issue(REQ_QUERY,  1'b1, KeyGenOff,  1'b1);
    issue(REQ_RECORD, 1'b1, KeyZero,    1'b0);
    issue(REQ_RECORD, 1'b0, KeyMixed,   1'b0);
    issue(REQ_QUERY,  1'b1, KeyMixed,   1'b1);
    issue(REQ_QUERY,  1'b0, KeyOnes,    1'b1);
    issue(REQ_QUERY,  1'b1, KeyZero,    1'b0);
    issue(REQ_QUERY,  1'b1, KeyMixed,   1'b0);
    issue(REQ_QUERY,  1'b0, KeyZero,    1'b1);
    issue(REQ_NOP,    1'b1, KeyOnes,    1'b1);
    issue(REQ_QUERY,  1'b1, KeyZero,    1'b0);
    issue(REQ_CLEAR,  1'b0, KeyZero,    1'b0);
    issue(REQ_QUERY,  1'b1, KeyZero,    1'b1);
    issue(REQ_QUERY,  1'b1, KeyZero,    1'b1);
    issue(REQ_RECORD, 1'b1, KeyMixed,   1'b1);
    issue(REQ_QUERY,  1'b1, KeyMixed,   1'b1);

    sent_items = 0;
    frame_idx  = 0;
    while (sent_items < RandomItems) begin
      steady_run = ($urandom_range(0, 3) == 0);
      run_frame(frame_idx == 0 || $urandom_range(0, 9) == 0);
      frame_idx++;
    end
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("resource_write_hazard_scoreboard_tb OK");
    end else begin
      $display("resource_write_hazard_scoreboard_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/rwhs_pkg.sv
design/rwhs_ctrl.sv
design/rwhs_dp.sv
design/resource_write_hazard_scoreboard.sv
tb/sv/resource_write_hazard_scoreboard_checker.sv
tb/sv/resource_write_hazard_scoreboard_tb.sv
